>>> rtl/core/swdr_pkg.sv
// ----------------------------------------------------------------------------
// swdr_pkg
// Shared types and constants of the sliding-window detector with refractory.
// ----------------------------------------------------------------------------
`default_nettype none

package swdr_pkg;

  // Default depth of the probability window.
  localparam int unsigned WindowLenDef = 8;

  // Field widths.
  localparam int unsigned ProbW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CutoffW  = 8;
  localparam int unsigned RefrW    = 16;
  localparam int unsigned CfgDataW = 16;

  // Register reset values.
  localparam logic [CutoffW-1:0] CutoffRst = 8'd127;
  localparam logic [RefrW-1:0]   RefrRst   = 16'd2000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_DETECT_CUTOFF = 1'b0,
    CFG_REFRACTORY_MS = 1'b1
  } cfg_idx_e;

  // Item mode.
  typedef enum logic [0:0] {
    MODE_PUSH  = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_e;

  // Control from the top level to the window ring.
  typedef struct packed {
    logic             push;
    logic             restart;
    logic [ProbW-1:0] prob;
  } ring_ctrl_t;

  // Window status after the push under way.
  typedef struct packed {
    logic full;
    logic over;
  } ring_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/swdr_if.sv
// ----------------------------------------------------------------------------
// swdr channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface swdr_in_if
  import swdr_pkg::*;
();
  logic              valid;
  logic              ready;
  mode_e             mode;
  logic [ProbW-1:0]  prob;
  logic [TimeW-1:0]  now_ms;

  modport source (output valid, output mode, output prob, output now_ms, input ready);
  modport sink   (input valid, input mode, input prob, input now_ms, output ready);
endinterface

interface swdr_out_if;
  logic valid;
  logic ready;
  logic wake_detected;

  modport source (output valid, output wake_detected, input ready);
  modport sink   (input valid, input wake_detected, output ready);
endinterface

interface swdr_cfg_if
  import swdr_pkg::*;
();
  logic                valid;
  logic                ready;
  cfg_idx_e            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/swdr_ring.sv
// ----------------------------------------------------------------------------
// swdr_ring
// Probability ring with running sum, fill count and write position.
// ----------------------------------------------------------------------------
`default_nettype none

module swdr_ring
  import swdr_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WindowLenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ring_ctrl_t         ctrl_i,
  input  wire logic [CutoffW-1:0] cutoff_i,
  output ring_stat_t              stat_o
);

  localparam int unsigned PosW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FillW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SumW  = $clog2(WINDOW_LEN * ((1 << ProbW) - 1) + 1);

  logic [ProbW-1:0]      mem_q [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] vld_q;
  logic [PosW-1:0]       pos_q, pos_d, pos_adv;
  logic [FillW-1:0]      fill_q, fill_d, fill_push;
  logic [SumW-1:0]       sum_q, sum_d, sum_push, thresh;
  logic [ProbW-1:0]      cur_q, evict;
  logic                  moved_q;
  logic [ProbW-1:0]      rdn_raw_q, rd0_raw_q, fwd_data_q;
  logic                  rdn_vld_q, rd0_vld_q, rdn_fwd_q, rd0_fwd_q;
  logic [ProbW-1:0]      rdn_val, rd0_val;

  // Position that follows the current one in ring order.
  assign pos_adv = (pos_q == PosW'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;

  // Read data for the two slots that can come next, with the last write forwarded.
  assign rdn_val = rdn_fwd_q ? fwd_data_q : (rdn_vld_q ? rdn_raw_q : '0);
  assign rd0_val = rd0_fwd_q ? fwd_data_q : (rd0_vld_q ? rd0_raw_q : '0);

  // Value held in the slot at the write position.
  assign evict = moved_q ? ((pos_q == '0) ? rd0_val : rdn_val) : cur_q;

  // Fill count, position and sum.
  always_comb begin
    fill_push = fill_q;
    if (ctrl_i.push && (fill_q != FillW'(WINDOW_LEN))) begin
      fill_push = fill_q + 1'b1;
    end
    fill_d = ctrl_i.restart ? '0 : fill_push;

    pos_d = pos_q;
    if (ctrl_i.restart) begin
      pos_d = '0;
    end else if (ctrl_i.push) begin
      pos_d = pos_adv;
    end

    sum_push = sum_q - SumW'(evict) + SumW'(ctrl_i.prob);
    sum_d    = ctrl_i.push ? sum_push : sum_q;
  end

  // Threshold scaled to a sum over the whole window.
  assign thresh = SumW'(cutoff_i) * SumW'(WINDOW_LEN);

  assign stat_o.full = (fill_push == FillW'(WINDOW_LEN));
  assign stat_o.over = (sum_push > thresh);

  // Ring storage and its registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[pos_q] <= ctrl_i.prob;
    end
    rdn_raw_q  <= mem_q[pos_adv];
    rd0_raw_q  <= mem_q[PosW'(0)];
    fwd_data_q <= ctrl_i.prob;
  end

  // Control state, valid bits and the held slot value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      cur_q     <= '0;
      moved_q   <= 1'b0;
      rdn_vld_q <= 1'b0;
      rd0_vld_q <= 1'b0;
      rdn_fwd_q <= 1'b0;
      rd0_fwd_q <= 1'b0;
    end else begin
      if (ctrl_i.push) begin
        vld_q[pos_q] <= 1'b1;
      end
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      cur_q     <= evict;
      moved_q   <= ctrl_i.push | ctrl_i.restart;
      rdn_vld_q <= vld_q[pos_adv];
      rd0_vld_q <= vld_q[PosW'(0)];
      rdn_fwd_q <= ctrl_i.push && (pos_q == pos_adv);
      rd0_fwd_q <= ctrl_i.push && (pos_q == '0);
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(WINDOW_LEN - 1))
    else $error("write position beyond window");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.restart |=> (fill_q == '0) && (pos_q == '0))
    else $error("restart did not clear fill count and position");
`endif

endmodule

`default_nettype wire

>>> rtl/core/swdr_decide.sv
// ----------------------------------------------------------------------------
// swdr_decide
// Refractory check, fire decision and last detection time.
// ----------------------------------------------------------------------------
`default_nettype none

module swdr_decide
  import swdr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [TimeW-1:0] now_ms_i,
  input  wire logic [RefrW-1:0] refractory_ms_i,
  input  wire ring_stat_t       stat_i,
  output logic                  fire_o
);

  logic [TimeW-1:0] last_fire_q;
  logic [TimeW-1:0] elapsed;
  logic             in_refr;

  // Wrapping elapsed time; a zero detection time means never fired.
  assign elapsed = now_ms_i - last_fire_q;
  assign in_refr = (last_fire_q != '0) && (elapsed < TimeW'(refractory_ms_i));

  assign fire_o = push_i && stat_i.full && stat_i.over && !in_refr;

  // Time of the last detection.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fire_q <= '0;
    end else if (fire_o) begin
      last_fire_q <= now_ms_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_detect_refractory.sv
// ----------------------------------------------------------------------------
// sliding_window_detect_refractory
// Moving-average threshold detector with a refractory period.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output is ready and returns
// one result beat per item: the item is captured in an input register,
// then the ring update, running-sum add and compare and the 32-bit elapsed
// time check run combinationally into the result register. A stalled result
// register holds the item in the input register; with the output ready the
// rate is one item per clock. The ring uses valid bits, so there is no
// clearing pass after reset. Register writes are accepted in every cycle.
`default_nettype none

module sliding_window_detect_refractory
  import swdr_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WindowLenDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  swdr_in_if.sink    in_i,
  swdr_out_if.source out_o,
  swdr_cfg_if.sink   cfg_i
);

  logic [CutoffW-1:0] cutoff_q;
  logic [RefrW-1:0]   refr_q;

  logic               s1_vld_q;
  mode_e              s1_mode_q;
  logic [ProbW-1:0]   s1_prob_q;
  logic [TimeW-1:0]   s1_now_q;
  logic               s1_go;

  logic               out_vld_q, out_vld_d;
  logic               out_wake_q;

  ring_ctrl_t         ring_ctrl;
  ring_stat_t         ring_stat;
  logic               push;
  logic               fire;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CutoffRst;
      refr_q   <= RefrRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DETECT_CUTOFF: cutoff_q <= cfg_i.data[CutoffW-1:0];
        CFG_REFRACTORY_MS: refr_q   <= cfg_i.data[RefrW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: it moves on when the result register is free.
  assign s1_go      = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_mode_q <= in_i.mode;
      s1_prob_q <= in_i.prob;
      s1_now_q  <= in_i.now_ms;
    end
  end

  // Ring and decision.
  assign push = s1_go && (s1_mode_q == MODE_PUSH);

  assign ring_ctrl.push    = push;
  assign ring_ctrl.restart = fire || (s1_go && (s1_mode_q == MODE_CLEAR));
  assign ring_ctrl.prob    = s1_prob_q;

  swdr_ring #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ring_ctrl),
    .cutoff_i (cutoff_q),
    .stat_o   (ring_stat)
  );

  swdr_decide u_decide (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .now_ms_i        (s1_now_q),
    .refractory_ms_i (refr_q),
    .stat_i          (ring_stat),
    .fire_o          (fire)
  );

  // Result register.
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_go) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_wake_q <= fire;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.wake_detected = out_wake_q;

`ifndef SYNTHESIS
  a_fire_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> ring_stat.full && ring_stat.over && (s1_mode_q == MODE_PUSH))
    else $error("fire without a full window over the threshold");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_go) |=> s1_vld_q && $stable(s1_now_q) && $stable(s1_prob_q))
    else $error("stalled input item lost or changed");

  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_vld_q)
    else $error("processed item gave no result beat");
`endif

endmodule

`default_nettype wire
